### hdl/swfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_pkg
// Shared types, constants and the CRC-8 step for the sensor word frame decoder.
// ----------------------------------------------------------------------------
package swfd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned NUM_W     = 2;
    localparam int unsigned TEMP_W    = 15;
    localparam int unsigned RH_W      = 14;
    localparam int unsigned IN_DATA_W = 8;
    localparam int unsigned OUT_DATA_W = 64;
    localparam int unsigned OUT_USER_W = 5;

    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [NUM_W-1:0]  WORDS_RESET = 2'd3;
    localparam logic [10:0]       READY_MASK = 11'h7FF;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] RH_SCALE    = 14'd10000;
    localparam logic [WORD_W-1:0] FULL_SCALE = 16'hFFFF;

    localparam logic [NUM_W-1:0] WORD_CO2  = 2'd0;
    localparam logic [NUM_W-1:0] WORD_TEMP = 2'd1;
    localparam logic [NUM_W-1:0] WORD_RH   = 2'd2;

    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_CRC  = 2'd2
    } t_phase;

    typedef struct packed {
        logic              produces;
        logic [WORD_W-1:0] word;
        logic [NUM_W-1:0]  num;
        logic              crc_ok;
        logic              last;
        logic              frame_ok;
        logic              data_ready;
        logic              full;
        logic [WORD_W-1:0] co2;
        logic [WORD_W-1:0] temp_raw;
    } t_word_info;

    typedef struct packed {
        logic [WORD_W-1:0] co2;
        logic [TEMP_W-1:0] temp;
        logic [RH_W-1:0]   rh;
    } t_meas;

    function automatic logic [BYTE_W-1:0] crc8_step(
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] crc;
        crc = crc_in ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (crc[BYTE_W-1]) begin
                crc = {crc[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[BYTE_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

### hdl/swfd_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_frame
// Byte framing, CRC-8 check and per-response bookkeeping.
// ----------------------------------------------------------------------------
module swfd_frame (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic [swfd_pkg::BYTE_W-1:0]     i_byte,
    input  logic                            i_first,
    input  logic [swfd_pkg::NUM_W-1:0]      i_words_expected,
    output swfd_pkg::t_word_info            o_info
);
    import swfd_pkg::*;

    t_phase            r_phase, n_phase, w_phase_eff;
    logic [NUM_W-1:0]  r_count, n_count, w_count_eff;
    logic              r_good, n_good, w_good_eff;
    logic [BYTE_W-1:0] r_high, n_high;
    logic [BYTE_W-1:0] r_low, n_low;
    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [WORD_W-1:0] r_co2, n_co2;
    logic [WORD_W-1:0] r_temp, n_temp;

    logic [BYTE_W-1:0] w_crc_new;
    logic [WORD_W-1:0] w_word;
    logic [NUM_W-1:0]  w_expected;
    logic              w_ok;
    logic              w_last;
    logic [WORD_W-1:0] w_co2_eff;

    assign w_phase_eff = i_first ? PH_HIGH : r_phase;
    assign w_count_eff = i_first ? '0 : r_count;
    assign w_good_eff  = i_first ? 1'b1 : r_good;

    assign w_crc_new  = crc8_step((w_phase_eff == PH_HIGH) ? CRC_INIT : r_crc, i_byte);
    assign w_word     = {r_high, r_low};
    assign w_ok       = (r_crc == i_byte);
    assign w_expected = (i_words_expected == '0) ? NUM_W'(1) : i_words_expected;
    assign w_last     = ({1'b0, w_count_eff} + 3'd1) >= {1'b0, w_expected};
    assign w_co2_eff  = (w_count_eff == WORD_CO2) ? w_word : r_co2;

    // next phase
    always_comb begin
        case (w_phase_eff)
            PH_HIGH: n_phase = PH_LOW;
            PH_LOW:  n_phase = PH_CRC;
            PH_CRC:  n_phase = PH_HIGH;
            default: n_phase = PH_HIGH;
        endcase
    end

    // datapath and result
    always_comb begin
        n_count = w_count_eff;
        n_good  = w_good_eff;
        n_high  = r_high;
        n_low   = r_low;
        n_crc   = r_crc;
        n_co2   = r_co2;
        n_temp  = r_temp;

        o_info            = '0;
        o_info.word       = w_word;
        o_info.num        = w_count_eff;
        o_info.crc_ok     = w_ok;
        o_info.last       = w_last;
        o_info.frame_ok   = w_good_eff & w_ok;
        o_info.co2        = w_co2_eff;
        o_info.temp_raw   = r_temp;

        case (w_phase_eff)
            PH_HIGH: begin
                n_high = i_byte;
                n_crc  = w_crc_new;
            end
            PH_LOW: begin
                n_low = i_byte;
                n_crc = w_crc_new;
            end
            PH_CRC: begin
                o_info.produces   = 1'b1;
                o_info.data_ready = w_last & ((w_co2_eff[10:0] & READY_MASK) != '0);
                o_info.full       = w_last & (w_count_eff == WORD_RH);
                if (w_count_eff == WORD_CO2) begin
                    n_co2 = w_word;
                end
                if (w_count_eff == WORD_TEMP) begin
                    n_temp = w_word;
                end
                if (w_last) begin
                    n_count = '0;
                    n_good  = 1'b1;
                end else begin
                    n_count = w_count_eff + NUM_W'(1);
                    n_good  = w_good_eff & w_ok;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HIGH;
            r_count <= '0;
            r_good  <= 1'b1;
            r_crc   <= CRC_INIT;
            r_high  <= '0;
            r_low   <= '0;
            r_co2   <= '0;
            r_temp  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_good  <= n_good;
            r_crc   <= n_crc;
            r_high  <= n_high;
            r_low   <= n_low;
            r_co2   <= n_co2;
            r_temp  <= n_temp;
        end
    end

endmodule

### hdl/swfd_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_scale
// Fixed-point conversion of the raw words to CO2, temperature and humidity.
// ----------------------------------------------------------------------------
module swfd_scale (
    input  swfd_pkg::t_word_info i_info,
    output swfd_pkg::t_meas      o_meas
);
    import swfd_pkg::*;

    logic [30:0] w_temp_prod;
    logic [29:0] w_rh_prod;
    logic [16:0] w_temp_rem;
    logic [16:0] w_rh_rem;
    logic [14:0] w_temp_q;
    logic [13:0] w_rh_q;

    // floor(x / 65535): x = q0 * 65536 + lo, so x = q0 * 65535 + (lo + q0);
    // lo + q0 stays below twice the divisor, one correction suffices
    assign w_temp_prod = {15'd0, i_info.temp_raw} * {16'd0, TEMP_SCALE};
    assign w_rh_prod   = {14'd0, i_info.word} * {16'd0, RH_SCALE};

    assign w_temp_rem = {1'b0, w_temp_prod[15:0]} + {2'b00, w_temp_prod[30:16]};
    assign w_rh_rem   = {1'b0, w_rh_prod[15:0]} + {3'b000, w_rh_prod[29:16]};

    assign w_temp_q = w_temp_prod[30:16] + 15'(w_temp_rem >= {1'b0, FULL_SCALE});
    assign w_rh_q   = w_rh_prod[29:16] + 14'(w_rh_rem >= {1'b0, FULL_SCALE});

    always_comb begin
        o_meas = '0;
        if (i_info.full) begin
            o_meas.co2  = i_info.co2;
            o_meas.temp = w_temp_q - TEMP_OFFSET;
            o_meas.rh   = w_rh_q;
        end
    end

endmodule

### hdl/sensor_word_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_word_frame_decoder
// Checks CRC-8 framed 16-bit words of a sensor response and converts them.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// s_axis    in         tvalid/tready           tdata: rx_byte, tuser: first_byte
// m_axis    out        tvalid/tready, tlast    tdata: word and measurements, tuser: flags
// cfg       in         i_cfg_we                i_cfg_wdata: words_expected
//
// One byte per cycle sustained while m_axis accepts results; a byte is held in the
// input register, and its result is loaded into the output register as it advances.
// Bytes that complete no word move on even while m_axis is stalled.
// Synchronous active-low reset clears framing, CRC state and words_expected (3).
// ----------------------------------------------------------------------------
module sensor_word_frame_decoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [swfd_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
    input  logic [0:0]                           s_axis_tuser,  // [0] first_byte
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [15:0] word_value, [31:16] co2_ppm, [46:32] temp_centi_c,
    // [60:47] rh_centi_pct, [63:61] zero
    output logic [swfd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [1:0] word_number, [2] crc_ok, [3] frame_ok, [4] data_ready
    output logic [swfd_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  logic                                 i_cfg_we,
    input  logic [swfd_pkg::NUM_W-1:0]           i_cfg_wdata
);
    import swfd_pkg::*;

    logic                  r_in_valid;
    logic [BYTE_W-1:0]     r_in_byte;
    logic                  r_in_first;
    logic [NUM_W-1:0]      r_words_expected;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic                  r_out_last;

    t_word_info            w_info;
    t_meas                 w_meas;
    logic                  w_out_free;
    logic                  w_advance;
    logic                  w_load;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && (!w_info.produces || w_out_free);
    assign w_load        = w_advance && w_info.produces;
    assign s_axis_tready = !r_in_valid || w_advance;

    swfd_frame u_frame (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (w_advance),
        .i_byte           (r_in_byte),
        .i_first          (r_in_first),
        .i_words_expected (r_words_expected),
        .o_info           (w_info)
    );

    swfd_scale u_scale (
        .i_info (w_info),
        .o_meas (w_meas)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_expected <= WORDS_RESET;
        end else if (i_cfg_we) begin
            r_words_expected <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata[BYTE_W-1:0];
            r_in_first <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {3'b000, w_meas.rh, w_meas.temp, w_meas.co2, w_info.word};
            r_out_user <= {w_info.data_ready, w_info.frame_ok, w_info.crc_ok, w_info.num};
            r_out_last <= w_info.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

### tb/sv/sensor_word_frame_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_word_frame_decoder_tb
// Self-checking bench for the CRC-8 framed sensor word decoder. Bytes go in
// on s_axis with random gaps. An in-bench predictor tracks framing, CRC and
// the fixed-point conversions, and each m_axis item is checked against the
// oldest predicted word. Word count settings 0..3 are swept between phases.
// ----------------------------------------------------------------------------
module sensor_word_frame_decoder_tb;
    import swfd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_BYTES = 50;

    class t_word_tracker;
        typedef struct packed {
            logic [15:0] word;
            logic [1:0]  num;
            logic        crc_ok;
            logic        last;
            logic        frame_ok;
            logic        data_ready;
            logic [15:0] co2;
            logic [14:0] temp;
            logic [13:0] rh;
        } t_word_result;

        t_word_result words_due [$];
        t_phase       phase     = PH_HIGH;
        logic [1:0]   count     = 2'd0;
        logic [7:0]   hi        = 8'd0;
        logic [7:0]   lo        = 8'd0;
        logic [7:0]   crc       = CRC_INIT;
        logic         all_good  = 1'b1;
        logic [15:0]  co2_word  = 16'd0;
        logic [15:0]  temp_word = 16'd0;
        logic [1:0]   words_cfg = WORDS_RESET;
        int           errors    = 0;

        static function logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            r = c ^ b;
            for (int i = 0; i < 8; i++) begin
                r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
            end
            return r;
        endfunction

        function void set_words(logic [1:0] v);
            words_cfg = v;
        endfunction

        function int pending();
            return words_due.size();
        endfunction

        function void take_byte(logic [7:0] b, logic first);
            t_word_result r;
            logic [31:0]  p;
            int           eff;
            if (first) begin
                phase = PH_HIGH;
                count = 2'd0;
                all_good = 1'b1;
            end
            case (phase)
                PH_HIGH: begin
                    hi = b;
                    crc = crc_next(CRC_INIT, b);
                    phase = PH_LOW;
                end
                PH_LOW: begin
                    lo = b;
                    crc = crc_next(crc, b);
                    phase = PH_CRC;
                end
                default: begin
                    phase = PH_HIGH;
                    r = '0;
                    r.word = {hi, lo};
                    r.num = count;
                    r.crc_ok = (crc == b);
                    all_good = all_good & r.crc_ok;
                    r.frame_ok = all_good;
                    eff = (words_cfg == 2'd0) ? 1 : int'(words_cfg);
                    r.last = (int'(count) + 1 >= eff);
                    if (count == WORD_CO2) begin
                        co2_word = r.word;
                    end else if (count == WORD_TEMP) begin
                        temp_word = r.word;
                    end
                    if (r.last) begin
                        r.data_ready = (co2_word[10:0] != 11'd0);
                        if (count == WORD_RH) begin
                            r.co2 = co2_word;
                            p = (32'd17500 * {16'd0, temp_word}) / 32'd65535 - 32'd4500;
                            r.temp = p[14:0];
                            p = (32'd10000 * {16'd0, r.word}) / 32'd65535;
                            r.rh = p[13:0];
                        end
                        count = 2'd0;
                        all_good = 1'b1;
                    end else begin
                        count = count + 2'd1;
                    end
                    words_due.push_back(r);
                end
            endcase
        endfunction

        function void check_word(logic [63:0] d, logic [4:0] u, logic l);
            t_word_result a;
            t_word_result e;
            a.word       = d[15:0];
            a.co2        = d[31:16];
            a.temp       = d[46:32];
            a.rh         = d[60:47];
            a.num        = u[1:0];
            a.crc_ok     = u[2];
            a.frame_ok   = u[3];
            a.data_ready = u[4];
            a.last       = l;
            if (words_due.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected word %h num %0d at %0t", a.word, a.num, $time);
                end
                return;
            end
            e = words_due.pop_front();
            if (a !== e) begin
                errors++;
                if (errors <= 10) begin
                    $display("word error at %0t", $time);
                    $display("  exp word %h num %0d crc %b last %b frame %b rdy %b",
                             e.word, e.num, e.crc_ok, e.last, e.frame_ok, e.data_ready);
                    $display("      co2 %h temp %h rh %h", e.co2, e.temp, e.rh);
                    $display("  got word %h num %0d crc %b last %b frame %b rdy %b",
                             a.word, a.num, a.crc_ok, a.last, a.frame_ok, a.data_ready);
                    $display("      co2 %h temp %h rh %h", a.co2, a.temp, a.rh);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] rx_byte
    logic [0:0]            s_axis_tuser;   // [0] first_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [15:0] word_value, [31:16] co2_ppm, [46:32] temp_centi_c, [60:47] rh_centi_pct
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [1:0] word_number, [2] crc_ok, [3] frame_ok, [4] data_ready
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  i_cfg_we;
    logic [NUM_W-1:0]      i_cfg_wdata;

    t_word_tracker tracker = new;
    logic        send_gaps;
    logic        recv_gaps;
    logic        hold_rx;
    logic [1:0]  words_now;
    logic [1:0]  word_plan [8];
    int          quiet_cycles = 0;

    sensor_word_frame_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            tracker.take_byte(s_axis_tdata, s_axis_tuser[0]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sensor_word_frame_decoder: mismatch");
            $finish;
        end
    end

    initial begin : rx_side
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_rx) begin
                hold_rx = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                end
            end
            gap = recv_gaps ? $urandom_range(0, 11) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = send_gaps ? $urandom_range(0, 11) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
    endtask

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return t_word_tracker::crc_next(t_word_tracker::crc_next(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        case ($urandom_range(0, 7))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            2: w = {5'($urandom_range(0, 31)), 11'h000};
            3: w = {5'd0, 11'($urandom)};
            default: w = 16'($urandom);
        endcase
        return w;
    endfunction

    task automatic send_word(input logic [15:0] w, input logic first, input logic corrupt);
        logic [7:0] c;
        c = word_crc(w);
        if (corrupt) c = c ^ (8'h01 << $urandom_range(0, 7));
        send_byte(w[15:8], first);
        send_byte(w[7:0], 1'b0);
        send_byte(c, 1'b0);
    endtask

    // Mostly whole responses with good CRCs; some cut short or corrupted.
    task automatic send_response(input int nwords, output int nbytes);
        logic [7:0]  frame_bytes [$];
        logic [15:0] w;
        logic [7:0]  c;
        logic        first;
        for (int k = 0; k < nwords; k++) begin
            w = pick_word();
            c = word_crc(w);
            if ($urandom_range(0, 7) == 0) c = c ^ (8'h01 << $urandom_range(0, 7));
            frame_bytes.push_back(w[15:8]);
            frame_bytes.push_back(w[7:0]);
            frame_bytes.push_back(c);
        end
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3 * nwords - 1) : 3 * nwords;
        first = ($urandom_range(0, 9) != 0);
        for (int k = 0; k < nbytes; k++) begin
            send_byte(frame_bytes[k], (k == 0) ? first : 1'b0);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_words(input logic [1:0] v);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_words(v);
        words_now = v;
    endtask

    initial begin : stimulus
        int sent;
        int nbytes;
        int eff;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_rst_n       = 1'b0;
        send_gaps     = 1'b0;
        recv_gaps     = 1'b0;
        hold_rx       = 1'b0;
        words_now     = WORDS_RESET;
        word_plan     = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd3};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full-scale words, then a cut word restarted by the first-byte mark
        send_word(16'h0000, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b0);
        send_byte(8'h07, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_word(16'h0801, 1'b1, 1'b1);
        send_word(16'h8000, 1'b0, 1'b0);
        send_word(16'h7FFF, 1'b0, 1'b0);
        // lower the word count in the middle of a response
        send_word(16'h1357, 1'b1, 1'b0);
        write_words(2'd1);
        send_word(16'h2468, 1'b0, 1'b0);

        for (int p = 0; p < 8; p++) begin
            write_words(word_plan[p]);
            send_gaps = (p == 2 || p == 4) ? 1'b0 : 1'($urandom_range(0, 1));
            recv_gaps = (p == 2 || p == 4) ? 1'b0 : 1'($urandom_range(0, 1));
            if (p == 4) hold_rx = 1'b1;
            eff = (words_now == 2'd0) ? 1 : int'(words_now);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
                    sent++;
                end else begin
                    send_response(eff, nbytes);
                    sent += nbytes;
                end
            end
        end

        settle();
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("sensor_word_frame_decoder: match");
        end else begin
            $display("sensor_word_frame_decoder: mismatch");
        end
        $finish;
    end
endmodule
